[rtl/positional_shift_list_defines.svh]
// Assertion macros for the positional shift list RTL.
// No dependencies; positional_shift_list.sv includes this header by name.
`ifndef POSITIONAL_SHIFT_LIST_DEFINES_SVH
`define POSITIONAL_SHIFT_LIST_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("%m: check failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: check failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[rtl/psl_pkg.sv]
// Shared types and constants for the positional shift list.
// No dependencies; imported by every module of the block.
package psl_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int CNT_OUT_W    = 8;
	localparam int DEF_CAPACITY = 128;

	// read tree: eight children per node
	localparam int TREE_SHIFT = 3;
	localparam int TREE_FANIN = 1 << TREE_SHIFT;

	// command codes
	localparam logic [1:0] CMD_INSERT      = 2'd0;
	localparam logic [1:0] CMD_DELETE      = 2'd1;
	localparam logic [1:0] CMD_READ        = 2'd2;
	localparam logic [1:0] CMD_REMOVE_LAST = 2'd3;

	// status codes
	localparam logic STATUS_DONE   = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef struct packed {
		logic [1:0]               cmd;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic                     status;
		logic signed [DATA_W-1:0] read_value;
		logic [CNT_OUT_W-1:0]     element_count;
		logic                     is_empty;
	} rsp_item_t;

	// per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
		logic rd;
	} cell_op_t;

endpackage

[rtl/positional_shift_list.sv]
// Positional shift list: CAPACITY cells in a row, insert/delete shift the cells from the position up at once.
// Sequence: capture the request, shift the cells, pass the registered read tree, then register the result; LEVELS =
// ceil(log2(CAPACITY)/3), the depth of the registered read tree (3 at 128 entries).
// One request at a time: req_stall holds off a new request until the result is registered.
// Reset: arst_n clears the element count and handshake state; cell contents stay undefined.
`include "positional_shift_list_defines.svh"

module positional_shift_list import psl_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int EXT_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int LEVELS = ($clog2(CAPACITY) + TREE_SHIFT - 1) / TREE_SHIFT;
	localparam int PH_W   = $clog2(LEVELS + 1);
	localparam logic [EXT_W-1:0] CAP_EXT    = EXT_W'(CAPACITY);
	localparam logic [PH_W-1:0]  LAST_PHASE = PH_W'(LEVELS);

	// control state
	logic             busy_q;
	logic [PH_W-1:0]  phase_q;
	logic [CNT_W-1:0] count_q;
	logic             rsp_valid_q;

	// captured request and result
	logic [1:0]        cmd_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] value_q;
	logic              status_q;
	rsp_item_t         rsp_q;

	logic             accept;
	logic             exec;
	logic             finish;
	logic             rsp_free;
	logic             ok;
	logic [CNT_W-1:0] count_nx;
	logic [EXT_W-1:0] pos_ext;
	logic [EXT_W-1:0] cnt_ext;
	cell_op_t         op;

	logic [DATA_W-1:0] cell_data [CAPACITY];
	logic [DATA_W-1:0] cell_rd   [CAPACITY];
	logic [DATA_W-1:0] tree_root;

	assign accept   = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign rsp_free = !rsp_valid_q || !rsp_stall;
	assign exec     = busy_q && (phase_q == '0);
	assign finish   = busy_q && (phase_q == LAST_PHASE) && rsp_free;

	assign pos_ext = EXT_W'(pos_q);
	assign cnt_ext = EXT_W'(count_q);

	// check the command against the count and work out the new count
	always_comb begin
		ok       = 1'b0;
		count_nx = count_q;
		case (cmd_q)
			CMD_INSERT: begin
				ok = (cnt_ext < CAP_EXT) && (pos_ext <= cnt_ext);
				if (ok) begin
					count_nx = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				ok = (pos_ext < cnt_ext);
				if (ok) begin
					count_nx = count_q - CNT_W'(1);
				end
			end
			CMD_READ: begin
				ok = (pos_ext < cnt_ext);
			end
			CMD_REMOVE_LAST: begin
				ok = (count_q != '0);
				if (ok) begin
					count_nx = count_q - CNT_W'(1);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// shift only in the first busy cycle; hold the read select while busy
	assign op.ins = exec && (cmd_q == CMD_INSERT) && ok;
	assign op.del = exec && (cmd_q == CMD_DELETE) && ok;
	assign op.rd  = busy_q && (cmd_q == CMD_READ) && ok;

	// sequence one request at a time through the cells and the read tree
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			phase_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				phase_q <= '0;
			end else begin
				if (finish) begin
					busy_q <= 1'b0;
				end
				if (busy_q && (phase_q != LAST_PHASE)) begin
					phase_q <= phase_q + PH_W'(1);
				end
			end
			if (exec) begin
				count_q <= count_nx;
			end
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// hold the request fields and the result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= req.cmd;
			pos_q   <= req.position;
			value_q <= req.value;
		end
		if (exec) begin
			status_q <= ok ? STATUS_DONE : STATUS_REJECT;
		end
		if (finish) begin
			rsp_q.status        <= status_q;
			rsp_q.read_value    <= $signed(tree_root);
			rsp_q.element_count <= cnt_ext[CNT_OUT_W-1:0];
			rsp_q.is_empty      <= (count_q == '0);
		end
	end

	// row of cells, each linked to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] lower;
		logic [DATA_W-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = '0;
		end else begin : g_inner_lo
			assign lower = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper = cell_data[i];
		end else begin : g_inner_hi
			assign upper = cell_data[i+1];
		end

		psl_cell #(
			.INDEX (i),
			.EXT_W (EXT_W)
		) u_cell (
			.clk   (clk),
			.op    (op),
			.pos   (pos_ext),
			.value (value_q),
			.lower (lower),
			.upper (upper),
			.data  (cell_data[i]),
			.rd    (cell_rd[i])
		);
	end

	psl_or_tree #(
		.N      (CAPACITY),
		.LEVELS (LEVELS)
	) u_tree (
		.clk  (clk),
		.leaf (cell_rd),
		.root (tree_root)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(CAPACITY))
	`ASSERT_NEXT(a_accept_starts, clk, arst_n, accept, busy_q && (phase_q == '0))
	`ASSERT_IMPLIES(a_rsp_from_last_phase, clk, arst_n, $rose(rsp_valid_q), $past(finish))
	`ASSERT_IMPLIES(a_count_moves_on_exec, clk, arst_n, !$stable(count_q), $past(exec))
	`ASSERT_IMPLIES(a_read_zero_on_reject, clk, arst_n, rsp_valid_q && (rsp_q.status == STATUS_REJECT), rsp_q.read_value == '0)

endmodule

[rtl/psl_cell.sv]
// One storage cell of the list row: holds one element and shifts with its neighbors.
// Depends on psl_pkg for data width and the cell command struct.
module psl_cell import psl_pkg::*; #(
	parameter int INDEX = 0,
	parameter int EXT_W = POS_W
) (
	input  logic              clk,
	input  cell_op_t          op,
	input  logic [EXT_W-1:0]  pos,
	input  logic [DATA_W-1:0] value,
	input  logic [DATA_W-1:0] lower,
	input  logic [DATA_W-1:0] upper,
	output logic [DATA_W-1:0] data,
	output logic [DATA_W-1:0] rd
);

	localparam logic [EXT_W-1:0] MY_INDEX = EXT_W'(INDEX);

	logic [DATA_W-1:0] data_q;
	logic              at_pos;
	logic              above_pos;

	assign at_pos    = (pos == MY_INDEX);
	assign above_pos = (pos < MY_INDEX);

	// insert: take the lower neighbor above the slot, load the new value at it
	// delete: take the upper neighbor at and above the slot
	always_ff @(posedge clk) begin
		if (op.ins && above_pos) begin
			data_q <= lower;
		end else if (op.ins && at_pos) begin
			data_q <= value;
		end else if (op.del && (at_pos || above_pos)) begin
			data_q <= upper;
		end
	end

	// drive the read tree only from the addressed cell
	assign rd   = (op.rd && at_pos) ? data_q : '0;
	assign data = data_q;

endmodule

[rtl/psl_or_tree.sv]
// Registered OR tree that gathers the single selected cell value to one word.
// Depends on psl_pkg for data width and fan-in; one register level per tree level.
module psl_or_tree import psl_pkg::*; #(
	parameter int N      = DEF_CAPACITY,
	parameter int LEVELS = 3
) (
	input  logic              clk,
	input  logic [DATA_W-1:0] leaf [N],
	output logic [DATA_W-1:0] root
);

	logic [DATA_W-1:0] lvl_d [LEVELS][N];
	logic [DATA_W-1:0] lvl_q [LEVELS][N];

	// combine up to eight children per node; level zero reads the leaves
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < N; j++) begin
				lvl_d[l][j] = '0;
				for (int k = 0; k < TREE_FANIN; k++) begin
					if (j * TREE_FANIN + k < N) begin
						if (l == 0) begin
							lvl_d[l][j] = lvl_d[l][j] | leaf[j * TREE_FANIN + k];
						end else begin
							lvl_d[l][j] = lvl_d[l][j] | lvl_q[l-1][j * TREE_FANIN + k];
						end
					end
				end
			end
		end
	end

	// advance one level per cycle
	always_ff @(posedge clk) begin
		lvl_q <= lvl_d;
	end

	assign root = lvl_q[LEVELS-1][0];

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for positional_shift_list: directed and random list commands,
// each response checked against a shadow list kept in the bench.
// Depends on psl_pkg and the positional_shift_list RTL.
module tb;
	import psl_pkg::*;

	localparam int LIST_CAP     = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 800;
	localparam int DRAIN_CYCLES = 20;
	localparam int CALM_START   = 1500;
	localparam int CALM_END     = 3000;

	// command mix of a random segment
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} cmd_mix_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	req_item_t                cmd_q[$];
	rsp_item_t                outcome_q[$];
	logic signed [DATA_W-1:0] shadow_cells [LIST_CAP];
	int                       shadow_count   = 0;
	int                       planned_count  = 0;
	int                       mismatch_count = 0;
	int                       cycle_count    = 0;

	positional_shift_list #(.CAPACITY(LIST_CAP)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// idle with a chance of 13 in 100, never inside the calm window
	function automatic logic idle_roll();
		if (cycle_count >= CALM_START && cycle_count < CALM_END)
			return 1'b0;
		return $urandom_range(99, 0) < 13;
	endfunction

	// apply one command to the shadow list and return the response it should give
	function automatic rsp_item_t list_outcome(req_item_t it);
		rsp_item_t res;
		int        pos;
		int        i;
		logic      ok;
		pos = int'(it.position);
		res = '0;
		ok  = 1'b0;
		case (it.cmd)
		CMD_INSERT: begin
			ok = shadow_count < LIST_CAP && pos <= shadow_count;
			if (ok) begin
				for (i = shadow_count; i > pos; i--)
					shadow_cells[i] = shadow_cells[i - 1];
				shadow_cells[pos] = it.value;
				shadow_count++;
			end
		end
		CMD_DELETE: begin
			ok = pos < shadow_count;
			if (ok) begin
				for (i = pos; i + 1 < shadow_count; i++)
					shadow_cells[i] = shadow_cells[i + 1];
				shadow_count--;
			end
		end
		CMD_READ: begin
			ok = pos < shadow_count;
			if (ok)
				res.read_value = shadow_cells[pos];
		end
		CMD_REMOVE_LAST: begin
			ok = shadow_count != 0;
			if (ok)
				shadow_count--;
		end
		endcase
		res.status        = ok ? STATUS_DONE : STATUS_REJECT;
		res.element_count = CNT_OUT_W'(shadow_count);
		res.is_empty      = (shadow_count == 0);
		return res;
	endfunction

	task automatic note_mismatch(string what, rsp_item_t want, rsp_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch %0d (%s): expected status=%0d read=%0d count=%0d empty=%0d, got status=%0d read=%0d count=%0d empty=%0d",
				mismatch_count, what, want.status, want.read_value, want.element_count,
				want.is_empty, got.status, got.read_value, got.element_count, got.is_empty);
	endtask

	// queue a command and track the count it leaves, to aim positions near the tail
	task automatic put_cmd(logic [1:0] c, int pos, logic [DATA_W-1:0] v);
		req_item_t it;
		it.cmd      = c;
		it.position = POS_W'(pos);
		it.value    = v;
		cmd_q.push_back(it);
		case (c)
		CMD_INSERT:      if (planned_count < LIST_CAP && pos <= planned_count) planned_count++;
		CMD_DELETE:      if (pos < planned_count) planned_count--;
		CMD_REMOVE_LAST: if (planned_count != 0) planned_count--;
		default:         ;
		endcase
	endtask

	task automatic put_random_cmd(cmd_mix_t mix);
		int               r;
		int               pos;
		logic [1:0]       c;
		logic [DATA_W-1:0] v;
		r = $urandom_range(99, 0);
		case (mix)
		MIX_GROW:   c = r < 75 ? CMD_INSERT : r < 83 ? CMD_DELETE : r < 93 ? CMD_READ : CMD_REMOVE_LAST;
		MIX_SHRINK: c = r < 15 ? CMD_INSERT : r < 50 ? CMD_DELETE : r < 75 ? CMD_READ : CMD_REMOVE_LAST;
		default:    c = r < 35 ? CMD_INSERT : r < 55 ? CMD_DELETE : r < 85 ? CMD_READ : CMD_REMOVE_LAST;
		endcase
		// favor extreme values now and then
		r = $urandom_range(99, 0);
		if (r < 3)
			v = 32'h7fff_ffff;
		else if (r < 6)
			v = 32'h8000_0000;
		else if (r < 8)
			v = '0;
		else if (r < 10)
			v = '1;
		else
			v = $urandom();
		// mostly legal positions, some at the edges, some anywhere in range
		r = $urandom_range(99, 0);
		if (r < 8 || c == CMD_REMOVE_LAST)
			pos = $urandom_range(128, 0);
		else if (c == CMD_INSERT)
			pos = r < 20 ? ($urandom_range(1, 0) ? planned_count : 0) : $urandom_range(planned_count, 0);
		else if (planned_count == 0)
			pos = 0;
		else
			pos = r < 20 ? ($urandom_range(1, 0) ? planned_count - 1 : 0)
				: $urandom_range(planned_count - 1, 0);
		put_cmd(c, pos, v);
	endtask

	// offer commands; predict each transfer as it happens
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || !req_stall) begin
			if (req_valid)
				outcome_q.push_back(list_outcome(req));
			if (cmd_q.size() != 0 && !idle_roll()) begin
				req_valid <= 1'b1;
				req       <= cmd_q.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// check each response transfer against the oldest prediction
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (outcome_q.size() == 0) begin
					note_mismatch("unexpected", '0, rsp);
				end else begin
					rsp_item_t want;
					want = outcome_q.pop_front();
					if (rsp.status !== want.status || rsp.read_value !== want.read_value
							|| rsp.element_count !== want.element_count
							|| rsp.is_empty !== want.is_empty)
						note_mismatch("field", want, rsp);
				end
			end
			rsp_stall <= idle_roll();
		end
	end

	initial begin
		int       n;
		int       seg_len;
		cmd_mix_t mix;
		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// empty list: everything but insert at the head is rejected
		put_cmd(CMD_READ, 0, '0);
		put_cmd(CMD_DELETE, 0, '0);
		put_cmd(CMD_REMOVE_LAST, 0, '0);
		put_cmd(CMD_INSERT, 1, 32'h1234_5678);
		// build a short list: head add, tail add, middle insert
		put_cmd(CMD_INSERT, 0, 32'h7fff_ffff);
		put_cmd(CMD_INSERT, 0, 32'h8000_0000);
		put_cmd(CMD_INSERT, 2, 32'hffff_ffff);
		put_cmd(CMD_INSERT, 1, 32'h0000_0000);
		for (n = 0; n <= 4; n++)
			put_cmd(CMD_READ, n, '0);
		// delete beyond count, head delete, middle delete
		put_cmd(CMD_DELETE, 4, '0);
		put_cmd(CMD_DELETE, 0, '0);
		put_cmd(CMD_DELETE, 1, '0);
		put_cmd(CMD_READ, 1, '0);
		put_cmd(CMD_REMOVE_LAST, 0, '0);
		// position equal to the capacity, beyond the count
		put_cmd(CMD_INSERT, 128, 32'hdead_beef);
		put_cmd(CMD_READ, 128, '0);
		put_cmd(CMD_DELETE, 128, '0);
		put_cmd(CMD_INSERT, 1, 32'h5555_aaaa);
		// drain to empty, then remove last once more
		put_cmd(CMD_REMOVE_LAST, 0, '0);
		put_cmd(CMD_REMOVE_LAST, 0, '0);
		put_cmd(CMD_REMOVE_LAST, 0, '0);

		// hold off until every response of the directed part is back
		while (cmd_q.size() != 0 || req_valid || outcome_q.size() != 0)
			@(posedge clk);

		// first segment fills the list and then pushes against full
		n = 0;
		mix = MIX_GROW;
		seg_len = 220;
		while (n < RANDOM_ITEMS) begin
			repeat (seg_len) begin
				put_random_cmd(mix);
				n++;
			end
			mix = cmd_mix_t'($urandom_range(2, 0));
			seg_len = $urandom_range(120, 30);
		end

		while (cmd_q.size() != 0 || req_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && outcome_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// stop a hung run
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/psl_pkg.sv
rtl/psl_cell.sv
rtl/psl_or_tree.sv
rtl/positional_shift_list.sv
verif/tb.sv
